/* hdl/arp_rr_pkg.sv */
// Package with the shared constants, codes and byte functions of the ARP request responder.
package arp_rr_pkg;

    // Frame geometry: Ethernet header plus ARP body.
    localparam int FRAME_LEN = 14 + 28;
    localparam int POS_W     = 6;
    localparam int MAC_W     = 48;
    localparam int IP_W      = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 48;

    // Header field positions within the frame.
    localparam int POS_CHECK_FIRST = 12;
    localparam int POS_CHECK_LAST  = 20;
    localparam int POS_OPCODE_LO   = 21;
    localparam int POS_TIP_FIRST   = 38;
    localparam int POS_TIP_LAST    = 41;

    // Opcode values.
    localparam logic [7:0] OPCODE_REQUEST = 8'h01;
    localparam logic [7:0] OPCODE_REPLY   = 8'h02;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOCAL_MAC   = 2'd0,
        CFG_GATEWAY_MAC = 2'd1,
        CFG_CLIENT_IP   = 2'd2
    } cfg_index_t;

    // Fixed header bytes: ethertype, hardware type, protocol, sizes, opcode.
    // Entry i serves frame position 12 + i; the last entry is the reply opcode
    // low byte, which the receive check replaces with the opcode test.
    function automatic logic [7:0] fixed_byte(input logic [3:0] i);
        logic [7:0] b;
        case (i)
            4'd0:    b = 8'h08;
            4'd1:    b = 8'h06;
            4'd2:    b = 8'h00;
            4'd3:    b = 8'h01;
            4'd4:    b = 8'h08;
            4'd5:    b = 8'h00;
            4'd6:    b = 8'h06;
            4'd7:    b = 8'h04;
            4'd8:    b = 8'h00;
            4'd9:    b = 8'h02;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Byte i of a MAC address, first byte most significant.
    function automatic logic [7:0] mac_byte(input logic [MAC_W-1:0] mac, input logic [2:0] i);
        logic [7:0] b;
        case (i)
            3'd0:    b = mac[47:40];
            3'd1:    b = mac[39:32];
            3'd2:    b = mac[31:24];
            3'd3:    b = mac[23:16];
            3'd4:    b = mac[15:8];
            3'd5:    b = mac[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Byte i of an IPv4 address, first byte most significant.
    function automatic logic [7:0] ip_byte(input logic [IP_W-1:0] ip, input logic [1:0] i);
        logic [7:0] b;
        case (i)
            2'd0:    b = ip[31:24];
            2'd1:    b = ip[23:16];
            2'd2:    b = ip[15:8];
            default: b = ip[7:0];
        endcase
        return b;
    endfunction

    // Byte k of the ARP reply frame.
    function automatic logic [7:0] reply_byte(
        input logic [POS_W-1:0] k,
        input logic [MAC_W-1:0] local_mac,
        input logic [MAC_W-1:0] gateway_mac,
        input logic [IP_W-1:0]  captured_ip,
        input logic [IP_W-1:0]  client_ip
    );
        logic [7:0] b;
        if (k < 6'd6)
            b = mac_byte(local_mac, 3'(k));
        else if (k < 6'd12)
            b = mac_byte(gateway_mac, 3'(k - 6'd6));
        else if (k < 6'd22)
            b = fixed_byte(4'(k - 6'd12));
        else if (k < 6'd28)
            b = mac_byte(gateway_mac, 3'(k - 6'd22));
        else if (k < 6'd32)
            b = ip_byte(captured_ip, 2'(k - 6'd28));
        else if (k < 6'd38)
            b = mac_byte(local_mac, 3'(k - 6'd32));
        else if (k < 6'd42)
            b = ip_byte(client_ip, 2'(k - 6'd38));
        else
            b = 8'h00;
        return b;
    endfunction

endpackage

/* hdl/arp_request_responder_core.sv */
// Top level of the ARP request responder: frame checker, reply generator and output register.
//
// Usage: frame bytes enter on rx_byte/rx_last, one transfer per cycle, under
// in_valid/in_stall. Results leave on tx_byte/tx_last/reply_sent under
// out_valid/out_stall. Every frame yields either a 42-byte ARP reply
// (reply_sent high on each byte, tx_last on the final one) or a single
// result with reply_sent low, tx_byte zero and tx_last high.
// Throughput: one input byte per cycle. Bytes before the last of a frame
// give no result and are never stalled, so the next frame streams in while
// a reply is still being generated. A last byte is stalled only while the
// reply generator is busy and is not handing its final result to the output
// register in that cycle. While the output register is free, the generator
// emits one result per cycle: each reply byte, or one for a rejected frame.
// A transferred last byte starts the generator, which loads the output
// register for transfer. With out_stall and out_valid high, the output
// register holds its result and the generator waits. Configuration is
// written through cfg_valid/cfg_ready (always ready); the user must write it
// only while the block is idle, as the block does not enforce it. Reset
// restores the frame state and zeroes configuration, generator and out_valid.
module arp_request_responder_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [arp_rr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [arp_rr_pkg::CFG_DAT_W-1:0]     cfg_data,
    // Input byte channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [7:0]                           rx_byte,
    input  logic                                 rx_last,
    // Result channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [7:0]                           tx_byte,
    output logic                                 tx_last,
    output logic                                 reply_sent
);

    localparam logic [arp_rr_pkg::POS_W-1:0] POS_FULL =
        arp_rr_pkg::POS_W'(arp_rr_pkg::FRAME_LEN);
    localparam logic [arp_rr_pkg::POS_W-1:0] IDX_END =
        arp_rr_pkg::POS_W'(arp_rr_pkg::FRAME_LEN - 1);

    // Configuration registers
    logic [arp_rr_pkg::MAC_W-1:0] local_mac_reg;
    logic [arp_rr_pkg::MAC_W-1:0] gateway_mac_reg;
    logic [arp_rr_pkg::IP_W-1:0]  client_ip_reg;

    // Receive frame state
    logic [arp_rr_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                         good_reg, good_next;
    logic                         req_reg, req_next;
    logic [arp_rr_pkg::IP_W-1:0]  tip_reg, tip_next;

    // Reply generator state
    logic                         gen_active_reg, gen_active_next;
    logic                         gen_reply_reg, gen_reply_next;
    logic [arp_rr_pkg::POS_W-1:0] gen_idx_reg, gen_idx_next;
    logic [arp_rr_pkg::IP_W-1:0]  tip_snap_reg, tip_snap_next;

    // Output register
    logic                         out_valid_reg, out_valid_next;
    logic [7:0]                   tx_byte_reg, tx_byte_next;
    logic                         tx_last_reg, tx_last_next;
    logic                         reply_sent_reg, reply_sent_next;

    logic in_xfer;
    logic out_free;
    logic emit;
    logic gen_final;

    // Handshake decisions. A last byte may enter in the cycle in which the
    // generator hands over its final result.
    assign cfg_ready = 1'b1;
    assign out_free  = ~out_valid_reg | ~out_stall;
    assign emit      = gen_active_reg & out_free;
    assign gen_final = ~gen_reply_reg | (gen_idx_reg == IDX_END);
    assign in_stall  = gen_active_reg & rx_last & ~(emit & gen_final);
    assign in_xfer   = in_valid & ~in_stall;

    // Configuration register writes; out-of-range indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_mac_reg   <= '0;
            gateway_mac_reg <= '0;
            client_ip_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                arp_rr_pkg::CFG_LOCAL_MAC:   local_mac_reg   <= cfg_data;
                arp_rr_pkg::CFG_GATEWAY_MAC: gateway_mac_reg <= cfg_data;
                arp_rr_pkg::CFG_CLIENT_IP:   client_ip_reg   <= cfg_data[arp_rr_pkg::IP_W-1:0];
                default:                     ;
            endcase
        end
    end

    // Header check of the incoming byte and the updated frame state.
    always_comb
    begin
        pos_next  = pos_reg;
        good_next = good_reg;
        req_next  = req_reg;
        tip_next  = tip_reg;
        if (pos_reg < POS_FULL)
        begin
            pos_next = pos_reg + 1'b1;
            if (pos_reg >= arp_rr_pkg::POS_W'(arp_rr_pkg::POS_CHECK_FIRST) &&
                pos_reg <= arp_rr_pkg::POS_W'(arp_rr_pkg::POS_CHECK_LAST))
            begin
                if (rx_byte != arp_rr_pkg::fixed_byte(
                        4'(pos_reg - arp_rr_pkg::POS_W'(arp_rr_pkg::POS_CHECK_FIRST))))
                    good_next = 1'b0;
            end
            else if (pos_reg == arp_rr_pkg::POS_W'(arp_rr_pkg::POS_OPCODE_LO))
            begin
                if (rx_byte == arp_rr_pkg::OPCODE_REQUEST)
                    req_next = 1'b1;
                else if (rx_byte != arp_rr_pkg::OPCODE_REPLY)
                    good_next = 1'b0;
            end
            else if (pos_reg >= arp_rr_pkg::POS_W'(arp_rr_pkg::POS_TIP_FIRST) &&
                     pos_reg <= arp_rr_pkg::POS_W'(arp_rr_pkg::POS_TIP_LAST))
            begin
                tip_next = {tip_reg[arp_rr_pkg::IP_W-9:0], rx_byte};
            end
        end
    end

    // Frame state registers; they return to reset values after the last byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            good_reg <= 1'b1;
            req_reg  <= 1'b0;
            tip_reg  <= '0;
        end
        else if (in_xfer)
        begin
            if (rx_last)
            begin
                pos_reg  <= '0;
                good_reg <= 1'b1;
                req_reg  <= 1'b0;
                tip_reg  <= '0;
            end
            else
            begin
                pos_reg  <= pos_next;
                good_reg <= good_next;
                req_reg  <= req_next;
                tip_reg  <= tip_next;
            end
        end
    end

    // Reply generator: started by a last byte, stepped by each emitted result.
    always_comb
    begin
        gen_active_next = gen_active_reg;
        gen_reply_next  = gen_reply_reg;
        gen_idx_next    = gen_idx_reg;
        tip_snap_next   = tip_snap_reg;
        if (emit)
        begin
            if (gen_final)
                gen_active_next = 1'b0;
            else
                gen_idx_next = gen_idx_reg + 1'b1;
        end
        if (in_xfer && rx_last)
        begin
            gen_active_next = 1'b1;
            gen_reply_next  = (pos_next == POS_FULL) & good_next & req_next;
            gen_idx_next    = '0;
            tip_snap_next   = tip_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_active_reg <= 1'b0;
            gen_reply_reg  <= 1'b0;
            gen_idx_reg    <= '0;
        end
        else
        begin
            gen_active_reg <= gen_active_next;
            gen_reply_reg  <= gen_reply_next;
            gen_idx_reg    <= gen_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tip_snap_reg <= tip_snap_next;
    end

    // Output register: loaded from the generator whenever it is free.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        tx_byte_next    = tx_byte_reg;
        tx_last_next    = tx_last_reg;
        reply_sent_next = reply_sent_reg;
        if (emit)
        begin
            out_valid_next  = 1'b1;
            tx_byte_next    = gen_reply_reg ?
                arp_rr_pkg::reply_byte(gen_idx_reg, local_mac_reg, gateway_mac_reg,
                                       tip_snap_reg, client_ip_reg) : 8'h00;
            tx_last_next    = gen_final;
            reply_sent_next = gen_reply_reg;
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        tx_byte_reg    <= tx_byte_next;
        tx_last_reg    <= tx_last_next;
        reply_sent_reg <= reply_sent_next;
    end

    assign out_valid  = out_valid_reg;
    assign tx_byte    = tx_byte_reg;
    assign tx_last    = tx_last_reg;
    assign reply_sent = reply_sent_reg;

`ifndef SYNTHESIS
    // A transferred last byte always starts the generator.
    a_last_starts_gen: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && rx_last) |=> gen_active_reg)
        else $error("last byte did not start the reply generator");

    // A rejected frame produces exactly one result, marked as the last.
    a_reject_single: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !gen_reply_reg) |=> (out_valid_reg && tx_last_reg && !reply_sent_reg))
        else $error("rejected frame did not end after one result");

    // The final reply byte carries the end mark, earlier ones do not.
    a_reply_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && gen_reply_reg) |=> (tx_last_reg == ($past(gen_idx_reg) == IDX_END)))
        else $error("reply end mark on the wrong byte");
`endif

endmodule

/* tb/sv/arp_reply_checker.sv */
// Checker that predicts the ARP responder's results from observed transfers and compares them.
`timescale 1ns / 1ps

module arp_reply_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [arp_rr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [arp_rr_pkg::CFG_DAT_W-1:0]   cfg_data,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic [7:0]                         rx_byte,
    input  logic                               rx_last,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic [7:0]                         tx_byte,
    input  logic                               tx_last,
    input  logic                               reply_sent,
    output int                                 errors,
    output int                                 pending,
    output int                                 results
);

    localparam int FRAME_LEN  = arp_rr_pkg::FRAME_LEN;
    localparam int MAX_PRINTS = 50;
    localparam int IMAGE_W    = 8 * FRAME_LEN;

    // Expected header bytes at frame positions 12 through 20.
    localparam logic [71:0] HDR_FIXED = 72'h08_06_00_01_08_00_06_04_00;

    typedef struct packed {
        logic [7:0] octet;
        logic       last;
        logic       sent;
    } tx_item_t;

    // Shadow copy of the configuration registers.
    logic [arp_rr_pkg::MAC_W-1:0] reg_local_mac;
    logic [arp_rr_pkg::MAC_W-1:0] reg_gateway_mac;
    logic [arp_rr_pkg::IP_W-1:0]  reg_client_ip;

    // Receive-side frame state of the predictor.
    int                           rx_pos;
    logic                         rx_good;
    logic                         rx_request;
    logic [arp_rr_pkg::IP_W-1:0]  rx_captured_ip;

    tx_item_t reply_q[$];
    int       err_count   = 0;
    int       match_count = 0;

    assign errors  = err_count;
    assign results = match_count;

    // Print one line for a mismatch and count it.
    task automatic report(input string what, input int got, input int want);
        if (err_count < MAX_PRINTS)
            $display("arp_reply_checker: %s: got %0h, expected %0h at %0t ns",
                     what, got, want, $time);
        err_count++;
    endtask

    // Clear the per-frame state, as the block does at the end of every frame.
    task automatic clear_rx();
        rx_pos         = 0;
        rx_good        = 1'b1;
        rx_request     = 1'b0;
        rx_captured_ip = '0;
    endtask

    // Fold one received byte into the header checks and the target IP capture.
    task automatic absorb_byte(input logic [7:0] b);
        if (rx_pos >= arp_rr_pkg::POS_CHECK_FIRST && rx_pos <= arp_rr_pkg::POS_CHECK_LAST) begin
            if (b != HDR_FIXED[71 - 8 * (rx_pos - arp_rr_pkg::POS_CHECK_FIRST) -: 8])
                rx_good = 1'b0;
        end
        else if (rx_pos == arp_rr_pkg::POS_OPCODE_LO) begin
            if (b == arp_rr_pkg::OPCODE_REQUEST)
                rx_request = 1'b1;
            else if (b != arp_rr_pkg::OPCODE_REPLY)
                rx_good = 1'b0;
        end
        else if (rx_pos >= arp_rr_pkg::POS_TIP_FIRST && rx_pos <= arp_rr_pkg::POS_TIP_LAST) begin
            rx_captured_ip = {rx_captured_ip[23:0], b};
        end
    endtask

    // On the last byte, queue either the full reply or the single reject result.
    task automatic predict_reply();
        logic [IMAGE_W-1:0] image;
        tx_item_t           item;
        if (rx_pos >= FRAME_LEN && rx_good && rx_request) begin
            image = {reg_local_mac, reg_gateway_mac, 16'h0806, 16'h0001, 16'h0800,
                     8'h06, 8'h04, 16'h0002, reg_gateway_mac, rx_captured_ip,
                     reg_local_mac, reg_client_ip};
            for (int k = 0; k < FRAME_LEN; k++) begin
                item.octet = image[IMAGE_W - 1 - 8 * k -: 8];
                item.last  = (k == FRAME_LEN - 1);
                item.sent  = 1'b1;
                reply_q.push_back(item);
            end
        end
        else begin
            item.octet = 8'h00;
            item.last  = 1'b1;
            item.sent  = 1'b0;
            reply_q.push_back(item);
        end
        clear_rx();
    endtask

    // Watch all three channels at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        tx_item_t want;
        if (!rst_n)
        begin
            reg_local_mac   = '0;
            reg_gateway_mac = '0;
            reg_client_ip   = '0;
            clear_rx();
            reply_q.delete();
            pending <= 0;
        end
        else
        begin
            // Register writes, masked to each register's width.
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    arp_rr_pkg::CFG_LOCAL_MAC:   reg_local_mac   = cfg_data;
                    arp_rr_pkg::CFG_GATEWAY_MAC: reg_gateway_mac = cfg_data;
                    arp_rr_pkg::CFG_CLIENT_IP:   reg_client_ip   = cfg_data[31:0];
                    default: ;
                endcase
            end

            // Compare each result transfer with the oldest expectation.
            if (out_valid && !out_stall)
            begin
                if (reply_q.size() == 0)
                    report("result with nothing expected", tx_byte, 0);
                else
                begin
                    want = reply_q.pop_front();
                    if (tx_byte !== want.octet)
                        report("tx_byte", tx_byte, want.octet);
                    if (tx_last !== want.last)
                        report("tx_last", tx_last, want.last);
                    if (reply_sent !== want.sent)
                        report("reply_sent", reply_sent, want.sent);
                    match_count++;
                end
            end

            // Update the frame state on each input transfer.
            if (in_valid && !in_stall)
            begin
                if (rx_pos < FRAME_LEN)
                begin
                    absorb_byte(rx_byte);
                    rx_pos++;
                end
                if (rx_last)
                    predict_reply();
            end

            pending <= reply_q.size();
        end
    end

endmodule

/* tb/sv/tb_top.sv */
// Top of the ARP responder testbench: clock, reset, frame stimulus, result stalls and verdict.
`timescale 1ns / 1ps

module tb_top;

    localparam int FRAME_LEN    = arp_rr_pkg::FRAME_LEN;
    localparam int TAIL_MAX     = 21;
    localparam int BUF_LEN      = FRAME_LEN + TAIL_MAX;
    localparam int ITEMS        = 310;
    localparam int PHASES       = 3;
    localparam int SETTLE       = 4;
    localparam int RESET_CYCLES = 12;

    // Index past the end of the register list; the block must ignore it.
    localparam logic [arp_rr_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // Ethertype, hardware type, protocol and sizes at frame positions 12 through 19.
    localparam logic [63:0] ARP_FIXED = 64'h0806_0001_0800_0604;

    typedef enum int { SET_RANDOM, SET_ONES, SET_ZEROS } reg_set_t;
    typedef enum int { FR_REQUEST, FR_REPLY, FR_SHORT, FR_CORRUPT, FR_NOISE } frame_kind_t;

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [arp_rr_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [arp_rr_pkg::CFG_DAT_W-1:0]   cfg_data;
    logic                               in_valid;
    logic                               in_stall;
    logic [7:0]                         rx_byte;
    logic                               rx_last;
    logic                               out_valid;
    logic                               out_stall;
    logic [7:0]                         tx_byte;
    logic                               tx_last;
    logic                               reply_sent;

    int errors;
    int pending;
    int results;

    logic [7:0] frame [0:BUF_LEN-1];
    int         frame_len;
    int         frame_count = 0;
    int         byte_count  = 0;
    int         write_count = 0;
    int         stall_run   = 0;
    logic       stall_level = 1'b0;

    arp_request_responder_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .rx_last    (rx_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .tx_byte    (tx_byte),
        .tx_last    (tx_last),
        .reply_sent (reply_sent)
    );

    arp_reply_checker mon (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .rx_last    (rx_last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .tx_byte    (tx_byte),
        .tx_last    (tx_last),
        .reply_sent (reply_sent),
        .errors     (errors),
        .pending    (pending),
        .results    (results)
    );

    // Free-running clock, 20 ns period.
    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Receiver stalls: long open stretches, short stalls, and a few long ones.
    always @(posedge clk)
    begin
        int r;
        if (stall_run == 0)
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
            begin
                stall_level = 1'b0;
                stall_run   = $urandom_range(1, 60);
            end
            else if (r < 90)
            begin
                stall_level = 1'b1;
                stall_run   = $urandom_range(1, 3);
            end
            else
            begin
                stall_level = 1'b1;
                stall_run   = $urandom_range(8, 30);
            end
        end
        stall_run = stall_run - 1;
        out_stall <= rst_n ? stall_level : 1'b0;
    end

    // Sender idle gap after a transfer: mostly none, some short, a few long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // An opcode low byte that is neither request nor reply.
    function automatic logic [7:0] bad_opcode();
        logic [7:0] b;
        b = 8'($urandom);
        while (b == arp_rr_pkg::OPCODE_REQUEST || b == arp_rr_pkg::OPCODE_REPLY)
            b = 8'($urandom);
        return b;
    endfunction

    // Length of the trailing bytes past the ARP body, usually none.
    function automatic int tail_len();
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(1, TAIL_MAX);
        return 0;
    endfunction

    // Fill the frame buffer with a well-formed ARP frame with random addresses.
    task automatic build_arp(input logic [7:0] opcode, input int tail);
        for (int i = 0; i < BUF_LEN; i++)
            frame[i] = 8'($urandom);
        for (int i = 0; i < 8; i++)
            frame[arp_rr_pkg::POS_CHECK_FIRST + i] = ARP_FIXED[63 - 8 * i -: 8];
        frame[arp_rr_pkg::POS_CHECK_LAST] = 8'h00;
        frame[arp_rr_pkg::POS_OPCODE_LO]  = opcode;
        frame_len = FRAME_LEN + tail;
    endtask

    // Spoil one checked header byte of the frame in the buffer.
    task automatic corrupt_header(input int pos);
        if (pos == arp_rr_pkg::POS_OPCODE_LO)
            frame[pos] = bad_opcode();
        else
            frame[pos] = frame[pos] ^ 8'($urandom_range(1, 255));
    endtask

    // Build a frame of the given kind in the buffer.
    task automatic make_frame(input frame_kind_t kind);
        case (kind)
            FR_REQUEST: build_arp(arp_rr_pkg::OPCODE_REQUEST, tail_len());
            FR_REPLY:   build_arp(arp_rr_pkg::OPCODE_REPLY, tail_len());
            FR_SHORT:
            begin
                build_arp(arp_rr_pkg::OPCODE_REQUEST, 0);
                frame_len = $urandom_range(1, FRAME_LEN - 1);
            end
            FR_CORRUPT:
            begin
                build_arp(arp_rr_pkg::OPCODE_REQUEST, tail_len());
                corrupt_header($urandom_range(arp_rr_pkg::POS_CHECK_FIRST,
                                              arp_rr_pkg::POS_OPCODE_LO));
            end
            default:
            begin
                build_arp(arp_rr_pkg::OPCODE_REQUEST, 0);
                for (int i = 0; i < BUF_LEN; i++)
                    frame[i] = 8'($urandom);
                frame_len = $urandom_range(1, BUF_LEN);
            end
        endcase
    endtask

    // Send the buffered frame byte by byte, with random gaps between transfers.
    task automatic send_frame();
        int gap;
        for (int i = 0; i < frame_len; i++)
        begin
            in_valid <= 1'b1;
            rx_byte  <= frame[i];
            rx_last  <= (i == frame_len - 1);
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            byte_count++;
            gap = gap_len();
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        frame_count++;
    endtask

    // Wait until every expected result has arrived and the block has settled.
    task automatic wait_idle();
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // One register write transfer.
    task automatic cfg_write(input logic [arp_rr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [arp_rr_pkg::CFG_DAT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        write_count++;
    endtask

    // Load all registers with one setting, then write the spare index; the client IP write also fills the upper bits.
    task automatic program_regs(input reg_set_t kind);
        logic [47:0] lmac;
        logic [47:0] gmac;
        logic [47:0] cip;
        case (kind)
            SET_ONES:
            begin
                lmac = '1;
                gmac = '1;
                cip  = '1;
            end
            SET_ZEROS:
            begin
                lmac = '0;
                gmac = '0;
                cip  = '0;
            end
            default:
            begin
                lmac = 48'({$urandom, $urandom});
                gmac = 48'({$urandom, $urandom});
                cip  = 48'({$urandom, $urandom});
            end
        endcase
        cfg_write(arp_rr_pkg::CFG_LOCAL_MAC, lmac);
        cfg_write(arp_rr_pkg::CFG_GATEWAY_MAC, gmac);
        cfg_write(arp_rr_pkg::CFG_CLIENT_IP, cip);
        cfg_write(CFG_SPARE, 48'({$urandom, $urandom}));
    endtask

    // Pick a random frame kind, weighted toward valid requests.
    function automatic frame_kind_t pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return FR_REQUEST;
        else if (r < 65)
            return FR_REPLY;
        else if (r < 75)
            return FR_SHORT;
        else if (r < 93)
            return FR_CORRUPT;
        return FR_NOISE;
    endfunction

    // Main stimulus: reset, directed frames, then random phases under several settings.
    initial
    begin
        int phase_goal;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        rx_byte   = '0;
        rx_last   = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A request with the longest tail of ignored bytes, answered with the
        // registers still at their reset values.
        build_arp(arp_rr_pkg::OPCODE_REQUEST, TAIL_MAX);
        send_frame();
        wait_idle();
        program_regs(SET_RANDOM);

        // A frame of one byte.
        frame[0]  = 8'hFF;
        frame_len = 1;
        send_frame();

        // A reply opcode gets no answer.
        build_arp(arp_rr_pkg::OPCODE_REPLY, 0);
        send_frame();

        // A request cut one byte short.
        build_arp(arp_rr_pkg::OPCODE_REQUEST, 0);
        frame_len = FRAME_LEN - 1;
        send_frame();

        // Wrong ethertype and an unknown opcode.
        build_arp(arp_rr_pkg::OPCODE_REQUEST, 0);
        corrupt_header(arp_rr_pkg::POS_CHECK_FIRST);
        send_frame();
        build_arp(arp_rr_pkg::OPCODE_REQUEST, 0);
        corrupt_header(arp_rr_pkg::POS_OPCODE_LO);
        send_frame();

        // Random frames, one register setting per phase, sharing what is left
        // of the byte budget.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            case (ph)
                0:       program_regs(SET_ONES);
                1:       program_regs(SET_ZEROS);
                default: program_regs(SET_RANDOM);
            endcase
            phase_goal = byte_count + (ITEMS - byte_count) / (PHASES - ph);
            do
            begin
                make_frame(pick_kind());
                send_frame();
            end
            while (byte_count < phase_goal);
        end

        wait_idle();
        $display("tb_top: %0d frames, %0d bytes in, %0d results checked, %0d register writes",
                 frame_count, byte_count, results, write_count);
        $display("tb_top: settings were reset, random, all ones and all zeros; frames were %s",
                 "requests, replies, short, corrupted and noise");
        if (errors == 0 && pending == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // Watchdog on the whole run.
    initial
    begin
        #10_000_000;
        $display("tb_top: timeout with %0d results still expected", pending);
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
